FILE: rtl/core/imra_pkg.sv
// ----------------------------------------------------------------------------
// imra_pkg
// shared types and constants for the interval map range assign block
// ----------------------------------------------------------------------------
package imra_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int STAT_W   = 2;

	localparam logic       OP_ASSIGN = 1'b0;
	localparam logic       OP_LOOKUP = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [KEY_W-1:0]  key_begin;
		logic [KEY_W-1:0]  key_end;
		logic [VAL_W-1:0]  value_in;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0]  value_out;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  entry_count;
	} out_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic              cmp;
		logic [KEY_W-1:0]  key_b;
		logic [KEY_W-1:0]  key_e;
		logic              shl;
		logic              shr;
		logic [IDX_W-1:0]  pos;
		logic              wa;
		logic [IDX_W-1:0]  pos_a;
		logic [KEY_W-1:0]  key_a;
		logic [VAL_W-1:0]  val_a;
		logic              wb;
		logic [IDX_W-1:0]  pos_b;
		logic [KEY_W-1:0]  key_wb;
		logic [VAL_W-1:0]  val_wb;
	} cell_cmd_t;

	typedef struct packed {
		logic lt_b;
		logic le_b;
		logic le_e;
	} cell_flags_t;

endpackage

FILE: rtl/core/imra_cell.sv
// ----------------------------------------------------------------------------
// imra_cell
// one breakpoint slot: holds key and value, compares, shifts with neighbors
// ----------------------------------------------------------------------------
module imra_cell (
	input  logic                          clk,
	input  logic [imra_pkg::IDX_W-1:0]    idx,
	input  imra_pkg::cell_cmd_t           cmd,
	input  logic [imra_pkg::KEY_W-1:0]    left_key,
	input  logic [imra_pkg::VAL_W-1:0]    left_val,
	input  logic [imra_pkg::KEY_W-1:0]    right_key,
	input  logic [imra_pkg::VAL_W-1:0]    right_val,
	output logic [imra_pkg::KEY_W-1:0]    key,
	output logic [imra_pkg::VAL_W-1:0]    val,
	output imra_pkg::cell_flags_t         flags
);

	logic [imra_pkg::KEY_W-1:0] key_q;
	logic [imra_pkg::VAL_W-1:0] val_q;
	imra_pkg::cell_flags_t      flags_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			flags_q.lt_b <= $signed(key_q) <  $signed(cmd.key_b);
			flags_q.le_b <= $signed(key_q) <= $signed(cmd.key_b);
			flags_q.le_e <= $signed(key_q) <= $signed(cmd.key_e);
		end
		if (cmd.shl && idx >= cmd.pos) begin
			key_q <= right_key;
			val_q <= right_val;
		end else if (cmd.shr && idx >= cmd.pos) begin
			key_q <= left_key;
			val_q <= left_val;
		end else if (cmd.wa && idx == cmd.pos_a) begin
			key_q <= cmd.key_a;
			val_q <= cmd.val_a;
		end else if (cmd.wb && idx == cmd.pos_b) begin
			key_q <= cmd.key_wb;
			val_q <= cmd.val_wb;
		end
	end

	assign key   = key_q;
	assign val   = val_q;
	assign flags = flags_q;

endmodule

FILE: rtl/core/interval_map_range_assign.sv
// ----------------------------------------------------------------------------
// interval_map_range_assign
// sorted breakpoint table in a row of cells with range assign and lookup
// ----------------------------------------------------------------------------
// channel   direction  handshake                 word
// cmd       in         start && !busy            in_word_t
// result    out        done strobe, one cycle    out_word_t
// cfg       in         cfg_valid && cfg_ready    initial_value
//
// lookup, empty interval, table full: compare, select, then strobe; busy drops with the strobe
// assign: compare, select, shift (0 to CAPACITY slots), write, then strobe
// the shift runs through the cell row one position per cycle
// reset clears count, state and initial value; table contents stay undefined
// the receiver cannot stall; busy holds off new words until the strobe
// ----------------------------------------------------------------------------
module interval_map_range_assign (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  imra_pkg::in_word_t            cmd,
	output logic                          done,
	output imra_pkg::out_word_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [imra_pkg::VAL_W-1:0]    cfg_data
);

	localparam int CAP   = imra_pkg::CAPACITY;
	localparam int CW    = imra_pkg::CNT_W;
	localparam int IW    = imra_pkg::IDX_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CMP   = 5'b00010,
		S_SEL   = 5'b00100,
		S_SHIFT = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	state_t                       state_q;
	imra_pkg::in_word_t           in_q;
	logic [imra_pkg::VAL_W-1:0]   init_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                total_q;
	logic [CW-1:0]                lo_q;
	logic [CW-1:0]                shift_q;
	logic                         shl_q;
	logic [IW-1:0]                pos_q;
	logic                         add_mid_q;
	logic                         add_end_q;
	logic [imra_pkg::VAL_W-1:0]   vend_q;
	logic                         done_q;
	imra_pkg::out_word_t          out_q;

	imra_pkg::cell_cmd_t          ccmd;
	logic [imra_pkg::KEY_W-1:0]   keys [CAP];
	logic [imra_pkg::VAL_W-1:0]   vals [CAP];
	imra_pkg::cell_flags_t        flg  [CAP];

	genvar g;
	generate
		for (g = 0; g < CAP; g++) begin : g_cell
			imra_cell u_cell (
				.clk       (clk),
				.idx       (IW'(g)),
				.cmd       (ccmd),
				.left_key  (g == 0 ? keys[0] : keys[(g == 0) ? 0 : g - 1]),
				.left_val  (g == 0 ? vals[0] : vals[(g == 0) ? 0 : g - 1]),
				.right_key (g == CAP - 1 ? keys[CAP-1] : keys[(g == CAP - 1) ? g : g + 1]),
				.right_val (g == CAP - 1 ? vals[CAP-1] : vals[(g == CAP - 1) ? g : g + 1]),
				.key       (keys[g]),
				.val       (vals[g]),
				.flags     (flg[g])
			);
		end
	endgenerate

	// boundary search over the registered flags
	logic [CAP:0]                 fb, fe, fl;
	logic [CW-1:0]                lo, hi, lk;
	logic [imra_pkg::VAL_W-1:0]   vb_sel, ve_sel, vl_sel;
	logic [imra_pkg::VAL_W-1:0]   vbefore, vend, vlook;
	logic                         add_mid, add_end;
	logic [CW-1:0]                span, m;
	logic [CW:0]                  total;
	logic                         empty_iv;

	always_comb begin
		fb = '0;
		fe = '0;
		fl = '0;
		for (int j = 0; j < CAP; j++) begin
			fb[j] = flg[j].lt_b && (CW'(j) < count_q);
			fe[j] = flg[j].le_e && (CW'(j) < count_q);
			fl[j] = flg[j].le_b && (CW'(j) < count_q);
		end
		lo = '0;
		hi = '0;
		lk = '0;
		vb_sel = '0;
		ve_sel = '0;
		vl_sel = '0;
		for (int j = 0; j < CAP; j++) begin
			if (fb[j] && !fb[j+1]) begin
				lo = lo | CW'(j + 1);
				vb_sel = vb_sel | vals[j];
			end
			if (fe[j] && !fe[j+1]) begin
				hi = hi | CW'(j + 1);
				ve_sel = ve_sel | vals[j];
			end
			if (fl[j] && !fl[j+1]) begin
				lk = lk | CW'(j + 1);
				vl_sel = vl_sel | vals[j];
			end
		end
		vbefore  = (lo == '0) ? init_q : vb_sel;
		vend     = (hi == '0) ? init_q : ve_sel;
		vlook    = (lk == '0) ? init_q : vl_sel;
		add_mid  = in_q.value_in != vbefore;
		add_end  = vend != in_q.value_in;
		span     = hi - lo;
		m        = CW'(add_mid) + CW'(add_end);
		total    = (CW+1)'(lo) + (CW+1)'(m) + (CW+1)'(count_q) - (CW+1)'(hi);
		empty_iv = !($signed(in_q.key_begin) < $signed(in_q.key_end));
	end

	always_comb begin
		ccmd        = '0;
		ccmd.cmp    = state_q == S_CMP;
		ccmd.key_b  = in_q.key_begin;
		ccmd.key_e  = in_q.key_end;
		ccmd.shl    = (state_q == S_SHIFT) && (shift_q != '0) && shl_q;
		ccmd.shr    = (state_q == S_SHIFT) && (shift_q != '0) && !shl_q;
		ccmd.pos    = pos_q;
		ccmd.wa     = (state_q == S_WRITE) && add_mid_q;
		ccmd.pos_a  = lo_q[IW-1:0];
		ccmd.key_a  = in_q.key_begin;
		ccmd.val_a  = in_q.value_in;
		ccmd.wb     = (state_q == S_WRITE) && add_end_q;
		ccmd.pos_b  = IW'(lo_q + CW'(add_mid_q));
		ccmd.key_wb = in_q.key_end;
		ccmd.val_wb = vend_q;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) in_q <= cmd;
		if (state_q == S_SEL) begin
			lo_q      <= lo;
			add_mid_q <= add_mid;
			add_end_q <= add_end;
			vend_q    <= vend;
			total_q   <= total[CW-1:0];
			if (m > span) begin
				shl_q   <= 1'b0;
				shift_q <= m - span;
				pos_q   <= lo[IW-1:0];
			end else begin
				shl_q   <= 1'b1;
				shift_q <= span - m;
				pos_q   <= IW'(lo + m);
			end
		end else if (state_q == S_SHIFT && shift_q != '0) begin
			shift_q <= shift_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			init_q  <= '0;
			done_q  <= 1'b0;
			out_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) init_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					out_q.entry_count <= count_q;
					if (in_q.opcode == imra_pkg::OP_LOOKUP) begin
						out_q.value_out <= vlook;
						out_q.status    <= imra_pkg::ST_DONE;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else if (empty_iv) begin
						out_q.value_out <= '0;
						out_q.status    <= imra_pkg::ST_EMPTY;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else if (total > (CW+1)'(CAP)) begin
						out_q.value_out <= '0;
						out_q.status    <= imra_pkg::ST_FULL;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_q == '0) state_q <= S_WRITE;
				end
				S_WRITE: begin
					count_q           <= total_q;
					out_q.value_out   <= '0;
					out_q.status      <= imra_pkg::ST_DONE;
					out_q.entry_count <= total_q;
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign result    = out_q;
	assign cfg_ready = 1'b1;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("breakpoint count above capacity");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == S_CMP)
		else $error("accepted word did not enter compare");

	a_shift_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |=> (state_q == S_SHIFT || state_q == S_WRITE))
		else $error("shift left to a wrong state");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> ($past(state_q) == S_SEL || $past(state_q) == S_WRITE))
		else $error("strobe without a finished word");

endmodule
